// ===== hw/rtl/blcd_pkg.sv =====
// ----------------------------------------------------------------------------
// Backlight dim controller package
// Shared types, codes and constants for the level controller.
// ----------------------------------------------------------------------------
package blcd_pkg;

	localparam int unsigned LEVEL_CNT_W = 9;
	localparam int unsigned LEVEL_W     = 8;
	localparam int unsigned STEP_W      = 4;
	localparam int unsigned AMB_W       = 7;
	localparam int unsigned RES_CNT_W   = 6;

	localparam logic [LEVEL_CNT_W-1:0] LEVEL_CNT_RESET = 9'd16;
	localparam logic [LEVEL_CNT_W-1:0] LEVEL_CNT_MAX   = 9'd256;
	localparam logic [LEVEL_CNT_W-1:0] STEP_DIV        = 9'd20;
	// n / 20 == (n * 205) >> 12 for n up to 256
	localparam logic [7:0]             STEP_RECIP      = 8'd205;
	localparam int unsigned            STEP_SHIFT      = 12;

	localparam logic [AMB_W-1:0] AMB_START  = 7'd50;
	localparam logic [AMB_W-1:0] AMB_DARK   = 7'd30;
	localparam logic [AMB_W-1:0] AMB_BRIGHT = 7'd70;

	localparam logic [RES_CNT_W-1:0] MAX_RES = 6'd39;

	typedef enum logic {
		REG_LEVEL_COUNT = 1'b0,
		REG_HW_FADES    = 1'b1
	} reg_idx_e;

	typedef enum logic [2:0] {
		FN_UP      = 3'd0,
		FN_DOWN    = 3'd1,
		FN_SET_STD = 3'd2,
		FN_SET_DIM = 3'd3,
		FN_DIM     = 3'd4,
		FN_UNDIM   = 3'd5,
		FN_AMBIENT = 3'd6
	} func_e;

	typedef enum logic [1:0] {
		AMB_UNKNOWN = 2'd0,
		AMB_ON      = 2'd1,
		AMB_OFF     = 2'd2
	} amb_mode_e;

	typedef enum logic [1:0] {
		JOB_UP   = 2'd0,
		JOB_DOWN = 2'd1,
		JOB_MOVE = 2'd2
	} job_kind_e;

	typedef enum logic {
		BK_IDLE = 1'b0,
		BK_RAMP = 1'b1
	} back_state_e;

	typedef struct packed {
		job_kind_e          kind;
		logic [LEVEL_W-1:0] lvl;
	} job_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic               last;
	} res_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] top;
		logic [STEP_W-1:0]  step;
		logic               fades;
	} cfg_t;

	function automatic logic [LEVEL_CNT_W-1:0] eff_levels(input logic [LEVEL_CNT_W-1:0] lc);
		logic [LEVEL_CNT_W-1:0] n;
		n = lc;
		if (lc == '0) begin
			n = 9'd1;
		end else if (lc > LEVEL_CNT_MAX) begin
			n = LEVEL_CNT_MAX;
		end
		return n;
	endfunction

	function automatic logic [LEVEL_W-1:0] calc_top(input logic [LEVEL_CNT_W-1:0] lc);
		logic [LEVEL_CNT_W-1:0] t;
		t = eff_levels(lc) - 9'd1;
		return t[LEVEL_W-1:0];
	endfunction

	function automatic logic [STEP_W-1:0] calc_step(input logic [LEVEL_CNT_W-1:0] lc);
		logic [LEVEL_CNT_W-1:0] n;
		logic [16:0]            prod;
		logic [STEP_W-1:0]      st;
		n    = eff_levels(lc);
		prod = 17'(n) * 17'(STEP_RECIP);
		st   = prod[STEP_SHIFT+STEP_W-1:STEP_SHIFT];
		if (n < STEP_DIV) begin
			st = 4'd1;
		end
		return st;
	endfunction

endpackage

// ===== hw/rtl/blcd_job_q.sv =====
// ----------------------------------------------------------------------------
// Job queue
// Two-entry queue carrying level jobs from the front end to the ramp engine.
// ----------------------------------------------------------------------------
module blcd_job_q (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  blcd_pkg::job_t wr_data,
	output logic          full,
	input  logic          rd_en,
	output blcd_pkg::job_t rd_data,
	output logic          empty
);
	import blcd_pkg::*;

	job_t       mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       do_wr;
	logic       do_rd;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_wr) begin
				wp_q <= ~wp_q;
			end
			if (do_rd) begin
				rp_q <= ~rp_q;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wr_data;
		end
	end

endmodule

// ===== hw/rtl/blcd_front.sv =====
// ----------------------------------------------------------------------------
// Command front end
// Takes commands, keeps standard/dim/ambient state and issues level jobs.
// ----------------------------------------------------------------------------
module blcd_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [2:0]                 func,
	input  logic [7:0]                 target_level,
	input  logic [6:0]                 ambient_percent,
	input  logic                       restart_ambient,
	input  blcd_pkg::cfg_t             cfg,
	input  logic                       jq_full,
	output logic                       jq_push,
	output blcd_pkg::job_t             jq_data
);
	import blcd_pkg::*;

	logic [LEVEL_W-1:0] std_q;
	logic [LEVEL_W-1:0] dim_q;
	logic               dimmed_q;
	amb_mode_e          amb_q;

	logic [LEVEL_W-1:0] std_n;
	logic [LEVEL_W-1:0] dim_n;
	logic               dimmed_n;
	amb_mode_e          amb_n;
	amb_mode_e          amb_base;
	logic               set_std;
	logic [LEVEL_W-1:0] set_val;
	logic               job_v;
	logic               accept;

	assign accept  = push && !jq_full;
	assign jq_push = accept && job_v;

	always_comb begin
		std_n            = std_q;
		dim_n            = dim_q;
		dimmed_n         = dimmed_q;
		amb_n            = amb_q;
		amb_base         = restart_ambient ? AMB_UNKNOWN : amb_q;
		set_std          = 1'b0;
		set_val          = '0;
		job_v            = 1'b0;
		jq_data.kind     = JOB_MOVE;
		jq_data.lvl      = '0;
		case (func)
			FN_UP: begin
				job_v        = 1'b1;
				jq_data.kind = JOB_UP;
			end
			FN_DOWN: begin
				job_v        = 1'b1;
				jq_data.kind = JOB_DOWN;
			end
			FN_SET_STD: begin
				set_std = 1'b1;
				set_val = target_level;
			end
			FN_SET_DIM: begin
				dim_n = (std_q > target_level) ? target_level : std_q;
				if (dimmed_q) begin
					job_v       = 1'b1;
					jq_data.lvl = dim_n;
				end
			end
			FN_DIM: begin
				if (!dimmed_q) begin
					dimmed_n    = 1'b1;
					job_v       = 1'b1;
					jq_data.lvl = dim_q;
				end
			end
			FN_UNDIM: begin
				if (dimmed_q) begin
					dimmed_n    = 1'b0;
					job_v       = 1'b1;
					jq_data.lvl = std_q;
				end
			end
			FN_AMBIENT: begin
				amb_n = amb_base;
				if (amb_base == AMB_UNKNOWN) begin
					set_std = 1'b1;
					if (ambient_percent < AMB_START) begin
						set_val = cfg.top;
						amb_n   = AMB_ON;
					end else begin
						set_val = '0;
						amb_n   = AMB_OFF;
					end
				end else if (ambient_percent < AMB_DARK && amb_base != AMB_ON) begin
					set_std = 1'b1;
					set_val = cfg.top;
					amb_n   = AMB_ON;
				end else if (ambient_percent > AMB_BRIGHT && amb_base != AMB_OFF) begin
					set_std = 1'b1;
					set_val = '0;
					amb_n   = AMB_OFF;
				end
			end
			default: begin
			end
		endcase
		if (set_std) begin
			std_n = set_val;
			if (!dimmed_q) begin
				job_v       = 1'b1;
				jq_data.lvl = set_val;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			std_q    <= 8'd1;
			dim_q    <= 8'd1;
			dimmed_q <= 1'b0;
			amb_q    <= AMB_UNKNOWN;
		end else if (accept) begin
			std_q    <= std_n;
			dim_q    <= dim_n;
			dimmed_q <= dimmed_n;
			amb_q    <= amb_n;
		end
	end

endmodule

// ===== hw/rtl/blcd_back.sv =====
// ----------------------------------------------------------------------------
// Ramp engine
// Runs level jobs one step a cycle while the result queue has room, and queues the level writes.
// ----------------------------------------------------------------------------
module blcd_back (
	input  logic           clk,
	input  logic           arst_n,
	input  blcd_pkg::cfg_t cfg,
	input  logic           jq_empty,
	input  blcd_pkg::job_t jq_data,
	output logic           jq_pop,
	output logic           empty,
	input  logic           pop,
	output logic [7:0]     write_level,
	output logic           last_write
);
	import blcd_pkg::*;

	back_state_e          state_q;
	back_state_e          state_n;
	logic [LEVEL_W-1:0]   present_q;
	logic [LEVEL_W:0]     a_q;
	logic [LEVEL_W-1:0]   tgt_q;
	logic                 up_q;
	logic                 neg_q;
	logic [LEVEL_W-1:0]   held_q;
	logic                 held_v_q;
	logic [RES_CNT_W-1:0] cnt_q;

	res_t                 oq_q [2];
	logic                 oq_wp_q;
	logic                 oq_rp_q;
	logic [1:0]           oq_cnt_q;
	logic                 oq_full;
	logic                 oq_pop;
	logic                 oq_push;
	res_t                 oq_data;

	logic                 step_en;
	logic [LEVEL_W:0]     up_sum;
	logic [LEVEL_W-1:0]   up_lvl;
	logic [LEVEL_W-1:0]   dn_lvl;
	logic                 single_v;
	logic [LEVEL_W-1:0]   single_lvl;
	logic                 ramp_go;
	logic                 ramp_done;
	logic                 ramp_emit;
	logic                 start_ramp;
	logic                 take_job;

	assign oq_full  = (oq_cnt_q == 2'd2);
	assign empty    = (oq_cnt_q == 2'd0);
	assign oq_pop   = pop && !empty;
	assign step_en  = !oq_full;
	assign take_job = (state_q == BK_IDLE) && step_en && !jq_empty;

	// job decode and ramp step evaluation
	always_comb begin
		up_sum     = {1'b0, present_q} + 9'(cfg.step);
		up_lvl     = (up_sum > {1'b0, cfg.top}) ? cfg.top : up_sum[LEVEL_W-1:0];
		dn_lvl     = (present_q < 8'(cfg.step)) ? '0 : present_q - 8'(cfg.step);
		single_v   = 1'b0;
		single_lvl = up_lvl;
		ramp_go    = 1'b0;
		case (jq_data.kind)
			JOB_UP: begin
				single_v = 1'b1;
			end
			JOB_DOWN: begin
				single_v   = (dn_lvl <= cfg.top);
				single_lvl = dn_lvl;
			end
			JOB_MOVE: begin
				single_lvl = jq_data.lvl;
				if (cfg.fades) begin
					single_v = (jq_data.lvl <= cfg.top);
				end else begin
					ramp_go = (jq_data.lvl != present_q);
				end
			end
			default: begin
			end
		endcase
		if (up_q) begin
			ramp_done = (a_q > {1'b0, tgt_q}) || (a_q > {1'b0, cfg.top});
			ramp_emit = !ramp_done && (cnt_q < MAX_RES);
		end else begin
			ramp_done = neg_q || (a_q < {1'b0, tgt_q});
			ramp_emit = !ramp_done && (a_q <= {1'b0, cfg.top}) && (cnt_q < MAX_RES);
		end
	end

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			BK_IDLE: begin
				if (take_job && ramp_go) begin
					state_n = BK_RAMP;
				end
			end
			BK_RAMP: begin
				if (step_en && ramp_done) begin
					state_n = BK_IDLE;
				end
			end
			default: begin
				state_n = BK_IDLE;
			end
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		jq_pop        = 1'b0;
		oq_push       = 1'b0;
		oq_data.level = held_q;
		oq_data.last  = 1'b0;
		start_ramp    = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (take_job) begin
					jq_pop        = 1'b1;
					oq_push       = single_v;
					oq_data.level = single_lvl;
					oq_data.last  = 1'b1;
					start_ramp    = ramp_go;
				end
			end
			BK_RAMP: begin
				if (step_en) begin
					if (ramp_done) begin
						oq_push      = held_v_q;
						oq_data.last = 1'b1;
					end else if (ramp_emit) begin
						oq_push = held_v_q;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_IDLE;
			present_q <= '0;
			held_v_q  <= 1'b0;
			cnt_q     <= '0;
			up_q      <= 1'b0;
			neg_q     <= 1'b0;
		end else begin
			state_q <= state_n;
			if (take_job && single_v) begin
				present_q <= single_lvl;
			end
			if (start_ramp) begin
				held_v_q <= 1'b0;
				cnt_q    <= '0;
				up_q     <= (jq_data.lvl > present_q);
				neg_q    <= 1'b0;
			end else if (state_q == BK_RAMP && step_en) begin
				if (ramp_done) begin
					held_v_q <= 1'b0;
				end else begin
					if (ramp_emit) begin
						held_v_q  <= 1'b1;
						cnt_q     <= cnt_q + 6'd1;
						present_q <= a_q[LEVEL_W-1:0];
					end
					if (!up_q && a_q < 9'(cfg.step)) begin
						neg_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_ramp) begin
			a_q   <= {1'b0, present_q};
			tgt_q <= jq_data.lvl;
		end else if (state_q == BK_RAMP && step_en && !ramp_done) begin
			if (ramp_emit) begin
				held_q <= a_q[LEVEL_W-1:0];
			end
			if (up_q) begin
				a_q <= a_q + 9'(cfg.step);
			end else if (a_q >= 9'(cfg.step)) begin
				a_q <= a_q - 9'(cfg.step);
			end
		end
	end

	// result queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wp_q  <= 1'b0;
			oq_rp_q  <= 1'b0;
			oq_cnt_q <= 2'd0;
		end else begin
			if (oq_push) begin
				oq_wp_q <= ~oq_wp_q;
			end
			if (oq_pop) begin
				oq_rp_q <= ~oq_rp_q;
			end
			if (oq_push && !oq_pop) begin
				oq_cnt_q <= oq_cnt_q + 2'd1;
			end else if (oq_pop && !oq_push) begin
				oq_cnt_q <= oq_cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (oq_push) begin
			oq_q[oq_wp_q] <= oq_data;
		end
	end

	assign write_level = oq_q[oq_rp_q].level;
	assign last_write  = oq_q[oq_rp_q].last;

endmodule

// ===== hw/rtl/backlight_dim_ramp_controller.sv =====
// ----------------------------------------------------------------------------
// Backlight dim ramp controller
// Path: a single level write passes the job queue and then the result queue;
//   ramp writes also pass the step and held-level registers, plus any wait
//   behind earlier jobs.
// Throughput: one ramp step per cycle in the ramp engine while the result
//   queue has room.
// Reset: asynchronous; levels, dim state and ambient mode return to defaults.
// ----------------------------------------------------------------------------
module backlight_dim_ramp_controller (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic       cfg_index,
	input  logic [8:0] cfg_data,
	input  logic       push,
	output logic       full,
	input  logic [2:0] func,
	input  logic [7:0] target_level,
	input  logic [6:0] ambient_percent,
	input  logic       restart_ambient,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] write_level,
	output logic       last_write
);
	import blcd_pkg::*;

	logic [LEVEL_CNT_W-1:0] level_count_q;
	logic                   hw_fades_q;
	cfg_t                   cfg;
	logic                   jq_push;
	job_t                   jq_wdata;
	logic                   jq_full;
	logic                   jq_pop;
	job_t                   jq_rdata;
	logic                   jq_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_count_q <= LEVEL_CNT_RESET;
			hw_fades_q    <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_LEVEL_COUNT: level_count_q <= cfg_data;
				REG_HW_FADES:    hw_fades_q    <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		cfg.top   = calc_top(level_count_q);
		cfg.step  = calc_step(level_count_q);
		cfg.fades = hw_fades_q;
	end

	assign full = jq_full;

	blcd_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.func            (func),
		.target_level    (target_level),
		.ambient_percent (ambient_percent),
		.restart_ambient (restart_ambient),
		.cfg             (cfg),
		.jq_full         (jq_full),
		.jq_push         (jq_push),
		.jq_data         (jq_wdata)
	);

	blcd_job_q u_job_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (jq_push),
		.wr_data (jq_wdata),
		.full    (jq_full),
		.rd_en   (jq_pop),
		.rd_data (jq_rdata),
		.empty   (jq_empty)
	);

	blcd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.jq_empty    (jq_empty),
		.jq_data     (jq_rdata),
		.jq_pop      (jq_pop),
		.empty       (empty),
		.pop         (pop),
		.write_level (write_level),
		.last_write  (last_write)
	);

endmodule
